### rtl/kpd_pkg.sv
// constants, register codes and helper functions for the knock pattern detector
// no dependencies; used by knock_pattern_detector and its checker
package kpd_pkg;

   // fixed field widths
   localparam int SENSOR_COUNT = 3;
   localparam int SAMPLE_BITS  = 12;
   localparam int TIME_W       = 32;
   localparam int MS_W         = 16;
   localparam int PATTERN_W    = 18;
   localparam int PATTERN_SLOTS = PATTERN_W / 2;
   localparam int SENSOR_W     = 2;
   localparam int VERDICT_W    = 2;

   // default sizes
   localparam int SEQ_CAPACITY_DEF   = 16;
   localparam int PATTERN_LENGTH_DEF = 9;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = PATTERN_W;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SILENCE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN    = 3'd7;

   // register reset values
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD0_RST = 12'd900;
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD1_RST = 12'd500;
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD2_RST = 12'd1200;
   localparam logic [MS_W-1:0]        WINDOW_RST     = 16'd40;
   localparam logic [MS_W-1:0]        DEBOUNCE_RST   = 16'd200;
   localparam logic [MS_W-1:0]        SILENCE_RST    = 16'd3000;
   localparam logic                   ENABLE_RST     = 1'b1;
   localparam logic [PATTERN_W-1:0]   PATTERN_RST    = 18'd173312;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_SOLVED = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_FAILED = 2'd2;

   // slot idx of the expected pattern; slots past the register read as zero
   function automatic logic [SENSOR_W-1:0] pattern_entry(input logic [PATTERN_W-1:0] pat,
                                                         input int idx);
      logic [SENSOR_W-1:0] entry;
      entry = '0;
      if (idx < PATTERN_SLOTS) begin
         entry = pat[2*idx +: 2];
      end
      return entry;
   endfunction

endpackage

### rtl/knock_pattern_detector.sv
// knock pattern detector top level: window grouping, debounce, sequence store and judging
// depends on kpd_pkg
//
// Each transfer on the req_ channel carries one sample from each of the three piezo
// sensors and a millisecond timestamp. The block takes one transfer per clock cycle while
// req_stall is low and answers every one with exactly one rsp_ transfer: the whole update
// (window open/track/close, debounce, winner pick, append to the sequence store and the
// judgement against the expected pattern) is short compare logic from the inputs to the
// result or skid register, with the detector state written on the same edge. A two-entry
// output stage (result register plus skid register) keeps the input side running while
// rsp_stall is high for one cycle; req_stall rises only when both entries hold a result.
// Configuration registers are written through the csr_ channel, which is always ready;
// write them only while no transfer is in flight. The sequence store needs no clearing
// after reset since only entries below the fill count ever decide the verdict.
module knock_pattern_detector #(
   parameter int SEQ_CAPACITY   = kpd_pkg::SEQ_CAPACITY_DEF,
   parameter int PATTERN_LENGTH = kpd_pkg::PATTERN_LENGTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kpd_pkg::SAMPLE_BITS-1:0]     req_sample0,
   input  logic [kpd_pkg::SAMPLE_BITS-1:0]     req_sample1,
   input  logic [kpd_pkg::SAMPLE_BITS-1:0]     req_sample2,
   input  logic [kpd_pkg::TIME_W-1:0]          req_now_ms,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_knock_valid,
   output logic [kpd_pkg::SENSOR_W-1:0]        rsp_knock_sensor,
   output logic [kpd_pkg::VERDICT_W-1:0]       rsp_verdict,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SB      = kpd_pkg::SAMPLE_BITS;
   localparam int NS      = kpd_pkg::SENSOR_COUNT;
   localparam int TW      = kpd_pkg::TIME_W;
   localparam int MW      = kpd_pkg::MS_W;
   localparam int SW      = kpd_pkg::SENSOR_W;
   localparam int VW      = kpd_pkg::VERDICT_W;
   // fill count must hold both the capacity and the pattern length
   localparam int LEN_MAX = (SEQ_CAPACITY > PATTERN_LENGTH) ? SEQ_CAPACITY : PATTERN_LENGTH;
   localparam int LEN_W   = $clog2(LEN_MAX + 1);
   localparam int IDX_W   = $clog2(SEQ_CAPACITY);
   // entries that take part in the judgement
   localparam int CMP_LEN = (PATTERN_LENGTH < SEQ_CAPACITY) ? PATTERN_LENGTH : SEQ_CAPACITY;

   // configuration registers
   logic [SB-1:0]                  thr_ff [NS];
   logic [MW-1:0]                  window_ff;
   logic [MW-1:0]                  debounce_ff;
   logic [MW-1:0]                  silence_ff;
   logic                           enable_ff;
   logic [kpd_pkg::PATTERN_W-1:0]  pattern_ff;

   // detector state
   logic                           open_ff, open_in;
   logic [TW-1:0]                  start_ff, start_in;
   logic [SB-1:0]                  peak_ff [NS];
   logic [SB-1:0]                  peak_in [NS];
   logic [TW-1:0]                  last_knock_ff, last_knock_in;
   logic [TW-1:0]                  activity_ff, activity_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [SW-1:0]                  store_ff [SEQ_CAPACITY];

   // per-transfer results
   logic                           req_take;
   logic [SB-1:0]                  samp [NS];
   logic                           append;
   logic [SW-1:0]                  best;
   logic                           knock_valid_c;
   logic [SW-1:0]                  knock_sensor_c;
   logic [VW-1:0]                  verdict_c;

   // output stage: result register and skid register
   logic                           rsp_valid_ff;
   logic                           rsp_knock_valid_ff;
   logic [SW-1:0]                  rsp_knock_sensor_ff;
   logic [VW-1:0]                  rsp_verdict_ff;
   logic                           skid_valid_ff;
   logic                           skid_knock_valid_ff;
   logic [SW-1:0]                  skid_knock_sensor_ff;
   logic [VW-1:0]                  skid_verdict_ff;
   logic                           rsp_take;

   assign samp[0] = req_sample0;
   assign samp[1] = req_sample1;
   assign samp[2] = req_sample2;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0]   <= kpd_pkg::THRESHOLD0_RST;
         thr_ff[1]   <= kpd_pkg::THRESHOLD1_RST;
         thr_ff[2]   <= kpd_pkg::THRESHOLD2_RST;
         window_ff   <= kpd_pkg::WINDOW_RST;
         debounce_ff <= kpd_pkg::DEBOUNCE_RST;
         silence_ff  <= kpd_pkg::SILENCE_RST;
         enable_ff   <= kpd_pkg::ENABLE_RST;
         pattern_ff  <= kpd_pkg::PATTERN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            kpd_pkg::REG_THRESHOLD0: thr_ff[0]   <= csr_data[SB-1:0];
            kpd_pkg::REG_THRESHOLD1: thr_ff[1]   <= csr_data[SB-1:0];
            kpd_pkg::REG_THRESHOLD2: thr_ff[2]   <= csr_data[SB-1:0];
            kpd_pkg::REG_WINDOW:     window_ff   <= csr_data[MW-1:0];
            kpd_pkg::REG_DEBOUNCE:   debounce_ff <= csr_data[MW-1:0];
            kpd_pkg::REG_SILENCE:    silence_ff  <= csr_data[MW-1:0];
            kpd_pkg::REG_ENABLE:     enable_ff   <= csr_data[0];
            kpd_pkg::REG_PATTERN:    pattern_ff  <= csr_data[kpd_pkg::PATTERN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // one transfer's update: sensors in order, then window close, then judgement
   always_comb begin
      logic [SB-1:0] best_val;
      logic [SB-1:0] best_thr;
      logic          match;
      logic [SW-1:0] entry;

      open_in        = open_ff;
      start_in       = start_ff;
      peak_in        = peak_ff;
      last_knock_in  = last_knock_ff;
      activity_in    = activity_ff;
      len_in         = len_ff;
      append         = 1'b0;
      best           = '0;
      best_val       = '0;
      best_thr       = '0;
      knock_valid_c  = 1'b0;
      knock_sensor_c = '0;
      verdict_c      = kpd_pkg::VERDICT_NONE;
      match          = 1'b1;
      entry          = '0;

      // first sample at or above its threshold opens a window, later ones track peaks
      for (int i = 0; i < NS; i++) begin
         if (!open_in) begin
            if (samp[i] >= thr_ff[i]) begin
               open_in  = 1'b1;
               start_in = req_now_ms;
               for (int j = 0; j < NS; j++) begin
                  peak_in[j] = '0;
               end
               peak_in[i] = samp[i];
            end
         end else if (samp[i] > peak_in[i]) begin
            peak_in[i] = samp[i];
         end
      end

      // first sensor with the strict largest nonzero peak
      for (int i = 0; i < NS; i++) begin
         if (peak_in[i] > best_val) begin
            best_val = peak_in[i];
            best_thr = thr_ff[i];
            best     = SW'(i);
         end
      end

      if (open_in && (req_now_ms - start_in) >= {{(TW-MW){1'b0}}, window_ff}) begin
         open_in = 1'b0;
         if ((req_now_ms - last_knock_ff) >= {{(TW-MW){1'b0}}, debounce_ff}
             && best_val != '0 && best_val >= best_thr) begin
            last_knock_in = req_now_ms;
            // a disabled knock still restarts the debounce time
            if (enable_ff) begin
               if (len_ff < LEN_W'(SEQ_CAPACITY)) begin
                  append = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end
               activity_in    = req_now_ms;
               knock_valid_c  = 1'b1;
               knock_sensor_c = best;
            end
         end
      end

      // compare against the pattern, with the entry appended this transfer bypassed
      for (int i = 0; i < CMP_LEN; i++) begin
         entry = (append && len_ff == LEN_W'(i)) ? best : store_ff[i];
         if (entry != kpd_pkg::pattern_entry(pattern_ff, i)) begin
            match = 1'b0;
         end
      end

      if (len_in != '0 && (req_now_ms - activity_in) >= {{(TW-MW){1'b0}}, silence_ff}) begin
         verdict_c   = (match && len_in == LEN_W'(PATTERN_LENGTH)) ? kpd_pkg::VERDICT_SOLVED
                                                                  : kpd_pkg::VERDICT_FAILED;
         len_in      = '0;
         activity_in = '0;
      end
   end

   // detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         start_ff      <= '0;
         last_knock_ff <= '0;
         activity_ff   <= '0;
         len_ff        <= '0;
         for (int i = 0; i < NS; i++) begin
            peak_ff[i] <= '0;
         end
      end else if (req_take) begin
         open_ff       <= open_in;
         start_ff      <= start_in;
         last_knock_ff <= last_knock_in;
         activity_ff   <= activity_in;
         len_ff        <= len_in;
         peak_ff       <= peak_in;
      end
   end

   // sequence store, valid only below the fill count
   always_ff @(posedge clock) begin
      if (req_take && append) begin
         store_ff[len_ff[IDX_W-1:0]] <= best;
      end
   end

   // output stage
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_take;
         end
      end else if (req_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_knock_valid_ff  <= skid_knock_valid_ff;
            rsp_knock_sensor_ff <= skid_knock_sensor_ff;
            rsp_verdict_ff      <= skid_verdict_ff;
         end else begin
            rsp_knock_valid_ff  <= knock_valid_c;
            rsp_knock_sensor_ff <= knock_sensor_c;
            rsp_verdict_ff      <= verdict_c;
         end
      end else if (req_take) begin
         skid_knock_valid_ff  <= knock_valid_c;
         skid_knock_sensor_ff <= knock_sensor_c;
         skid_verdict_ff      <= verdict_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_knock_valid  = rsp_knock_valid_ff;
   assign rsp_knock_sensor = rsp_knock_sensor_ff;
   assign rsp_verdict      = rsp_verdict_ff;

endmodule

### rtl/kpd_checker.sv
// port-level checks for knock_pattern_detector, attached by the bind below
// depends on kpd_pkg
module kpd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_knock_valid,
   input logic [kpd_pkg::SENSOR_W-1:0]  rsp_knock_sensor,
   input logic [kpd_pkg::VERDICT_W-1:0] rsp_verdict
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_knock_valid)
         && $stable(rsp_knock_sensor) && $stable(rsp_verdict))
      else $error("stalled result changed");

   // no result right after a reset cycle
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // sensor index is zero without a recorded knock
   a_sensor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_knock_valid |-> rsp_knock_sensor == '0)
      else $error("sensor index without knock");

   // winner is one of the sensors
   a_sensor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_knock_valid |-> rsp_knock_sensor < 2'(kpd_pkg::SENSOR_COUNT))
      else $error("sensor index out of range");

   // verdict is none, solved or failed
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict == kpd_pkg::VERDICT_NONE
         || rsp_verdict == kpd_pkg::VERDICT_SOLVED || rsp_verdict == kpd_pkg::VERDICT_FAILED)
      else $error("bad verdict code");

endmodule

bind knock_pattern_detector kpd_checker u_kpd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_knock_valid  (rsp_knock_valid),
   .rsp_knock_sensor (rsp_knock_sensor),
   .rsp_verdict      (rsp_verdict)
);
